// ===== sv/dss_pkg.sv =====
package dss_pkg;

    localparam int DEPTH  = 256;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int IDX_W  = 8;

    typedef enum logic [2:0] {
        ACT_PUSH   = 3'd0,
        ACT_POP    = 3'd1,
        ACT_PEEK   = 3'd2,
        ACT_CLEAR  = 3'd3,
        ACT_SEARCH = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        action_t            action;
        logic               which_stack;
        logic [DATA_W-1:0]  value;
    } cmd_t;

    typedef struct packed {
        status_t            status;
        logic [DATA_W-1:0]  data;
        logic [IDX_W-1:0]   found_index;
        logic [CNT_W-1:0]   size_a;
        logic [CNT_W-1:0]   size_b;
        logic               is_full;
    } res_t;

endpackage

// ===== sv/dss_engine.sv =====
module dss_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  dss_pkg::cmd_t                 cmd,
    input  logic [dss_pkg::CNT_W-1:0]     capacity,
    input  logic                          cfg_clear,
    output logic                          res_valid,
    input  logic                          res_ready,
    output dss_pkg::res_t                 res
);

    dss_pkg::state_t                state_reg, state_next;
    dss_pkg::action_t               act_reg, act_next;
    logic                           stk_reg, stk_next;
    logic [dss_pkg::DATA_W-1:0]     val_reg, val_next;
    logic [dss_pkg::CNT_W-1:0]      cnt_a_reg, cnt_a_next;
    logic [dss_pkg::CNT_W-1:0]      cnt_b_reg, cnt_b_next;
    logic [dss_pkg::ADDR_W-1:0]     addr_reg, addr_next;
    logic [dss_pkg::CNT_W-1:0]      remain_reg, remain_next;
    dss_pkg::status_t               status_reg, status_next;
    logic [dss_pkg::DATA_W-1:0]     data_reg, data_next;
    logic [dss_pkg::IDX_W-1:0]      fidx_reg, fidx_next;

    logic [dss_pkg::DATA_W-1:0]     store_mem [dss_pkg::DEPTH];
    logic [dss_pkg::DATA_W-1:0]     rdata_reg;
    logic                           wr_en;
    logic [dss_pkg::ADDR_W-1:0]     wr_addr;

    logic [dss_pkg::CNT_W:0]        sum;
    logic                           full;
    logic [dss_pkg::CNT_W-1:0]      b_base;
    logic [dss_pkg::CNT_W-1:0]      cnt_sel;

    assign sum     = {1'b0, cnt_a_reg} + {1'b0, cnt_b_reg};
    assign full    = sum >= {1'b0, capacity};
    // lowest occupied entry of stack B, which is its top
    assign b_base  = capacity - cnt_b_reg;
    assign cnt_sel = stk_reg ? cnt_b_reg : cnt_a_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dss_pkg::S_IDLE;
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
        end else begin
            state_reg <= state_next;
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg    <= act_next;
        stk_reg    <= stk_next;
        val_reg    <= val_next;
        addr_reg   <= addr_next;
        remain_reg <= remain_next;
        status_reg <= status_next;
        data_reg   <= data_next;
        fidx_reg   <= fidx_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= val_reg;
        end
        rdata_reg <= store_mem[addr_next];
    end

    always_comb begin
        state_next  = state_reg;
        act_next    = act_reg;
        stk_next    = stk_reg;
        val_next    = val_reg;
        cnt_a_next  = cnt_a_reg;
        cnt_b_next  = cnt_b_reg;
        addr_next   = addr_reg;
        remain_next = remain_reg;
        status_next = status_reg;
        data_next   = data_reg;
        fidx_next   = fidx_reg;
        wr_en       = 1'b0;
        wr_addr     = '0;
        cmd_ready   = 1'b0;
        res_valid   = 1'b0;

        unique case (state_reg)
            dss_pkg::S_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    act_next    = cmd.action;
                    stk_next    = cmd.which_stack;
                    val_next    = cmd.value;
                    status_next = dss_pkg::STAT_OK;
                    data_next   = '0;
                    fidx_next   = '0;
                    state_next  = dss_pkg::S_EXEC;
                end
            end
            dss_pkg::S_EXEC: begin
                state_next = dss_pkg::S_DONE;
                unique case (act_reg)
                    dss_pkg::ACT_PUSH: begin
                        if (full) begin
                            status_next = dss_pkg::STAT_FULL;
                        end else if (!stk_reg) begin
                            wr_en      = 1'b1;
                            wr_addr    = cnt_a_reg[dss_pkg::ADDR_W-1:0];
                            cnt_a_next = cnt_a_reg + 1'b1;
                        end else begin
                            wr_en      = 1'b1;
                            wr_addr    = b_base[dss_pkg::ADDR_W-1:0] - 1'b1;
                            cnt_b_next = cnt_b_reg + 1'b1;
                        end
                    end
                    dss_pkg::ACT_POP, dss_pkg::ACT_PEEK: begin
                        if (cnt_sel == '0) begin
                            status_next = dss_pkg::STAT_EMPTY;
                        end else begin
                            addr_next  = stk_reg ? b_base[dss_pkg::ADDR_W-1:0]
                                                 : cnt_a_reg[dss_pkg::ADDR_W-1:0] - 1'b1;
                            state_next = dss_pkg::S_READ;
                            if (act_reg == dss_pkg::ACT_POP) begin
                                if (stk_reg) begin
                                    cnt_b_next = cnt_b_reg - 1'b1;
                                end else begin
                                    cnt_a_next = cnt_a_reg - 1'b1;
                                end
                            end
                        end
                    end
                    dss_pkg::ACT_CLEAR: begin
                        if (stk_reg) begin
                            cnt_b_next = '0;
                        end else begin
                            cnt_a_next = '0;
                        end
                    end
                    dss_pkg::ACT_SEARCH: begin
                        status_next = dss_pkg::STAT_NOT_FOUND;
                        if (cnt_sel != '0) begin
                            // start at the top; issue the first read now
                            addr_next   = stk_reg ? b_base[dss_pkg::ADDR_W-1:0]
                                                  : cnt_a_reg[dss_pkg::ADDR_W-1:0] - 1'b1;
                            remain_next = cnt_sel;
                            state_next  = dss_pkg::S_SCAN;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            dss_pkg::S_READ: begin
                data_next  = rdata_reg;
                state_next = dss_pkg::S_DONE;
            end
            dss_pkg::S_SCAN: begin
                // rdata_reg holds the entry at addr_reg
                if (rdata_reg == val_reg) begin
                    status_next = dss_pkg::STAT_OK;
                    fidx_next   = dss_pkg::IDX_W'(addr_reg);
                    state_next  = dss_pkg::S_DONE;
                end else if (remain_reg == dss_pkg::CNT_W'(1)) begin
                    state_next = dss_pkg::S_DONE;
                end else begin
                    remain_next = remain_reg - 1'b1;
                    addr_next   = stk_reg ? addr_reg + 1'b1 : addr_reg - 1'b1;
                end
            end
            dss_pkg::S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = dss_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = dss_pkg::S_IDLE;
            end
        endcase

        if (cfg_clear) begin
            cnt_a_next = '0;
            cnt_b_next = '0;
        end
    end

    assign res.status      = status_reg;
    assign res.data        = data_reg;
    assign res.found_index = fidx_reg;
    assign res.size_a      = cnt_a_reg;
    assign res.size_b      = cnt_b_reg;
    assign res.is_full     = full;

    a_sum_within_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        sum <= {1'b0, capacity})
        else $error("stack sizes exceed capacity");

    a_scan_remaining: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == dss_pkg::S_SCAN |-> remain_reg != '0)
        else $error("scan running with no entries left");

    a_found_in_stack_a: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && act_reg == dss_pkg::ACT_SEARCH && !stk_reg
            && status_reg == dss_pkg::STAT_OK
        |-> {1'b0, fidx_reg} < cnt_a_reg)
        else $error("search hit outside stack A");

    a_found_in_stack_b: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && act_reg == dss_pkg::ACT_SEARCH && stk_reg
            && status_reg == dss_pkg::STAT_OK
        |-> {1'b0, fidx_reg} >= b_base)
        else $error("search hit outside stack B");

endmodule

// ===== sv/dual_stack_shared_array_core.sv =====
// Two stacks in one 256-entry store: stack A grows up from entry 0, stack B
// grows down from entry capacity-1. Each transfer on the input carries one
// command (push, pop, peek, clear, search) and yields exactly one result with
// both stack sizes and a full flag. Commands run one at a time through a
// store with one read and one write port: pop and peek pass through an
// extra read state before the result, and a search scans the chosen stack
// from the top down, reading one store entry per cycle and stopping at the
// first match or after the last entry of that stack.
// A finished result sits in an output register, so the next command is taken
// while it waits. Writing capacity (clamped to 1..256) empties both stacks;
// write it only when no command is in flight.
module dual_stack_shared_array_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,  // value
    input  logic [3:0]                    s_axis_tuser,  // action[2:0], which_stack
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // data[31:0], found_index[39:32], size_a[48:40], size_b[57:49], is_full, pad
    output logic [63:0]                   m_axis_tdata,
    output logic [1:0]                    m_axis_tuser,  // status
    input  logic                          cfg_wr_en,
    input  logic [dss_pkg::CNT_W-1:0]     cfg_wr_data
);

    logic [dss_pkg::CNT_W-1:0]  capacity_reg, capacity_next;
    dss_pkg::cmd_t              cmd;
    dss_pkg::res_t              res;
    dss_pkg::res_t              out_reg;
    logic                       m_valid_reg, m_valid_next;
    logic                       res_valid;
    logic                       res_ready;

    always_comb begin
        capacity_next = capacity_reg;
        if (cfg_wr_en) begin
            priority if (cfg_wr_data == '0) begin
                capacity_next = dss_pkg::CNT_W'(1);
            end else if (cfg_wr_data > dss_pkg::CNT_W'(dss_pkg::DEPTH)) begin
                capacity_next = dss_pkg::CNT_W'(dss_pkg::DEPTH);
            end else begin
                capacity_next = cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= dss_pkg::CNT_W'(dss_pkg::DEPTH);
        end else begin
            capacity_reg <= capacity_next;
        end
    end

    assign cmd.action      = dss_pkg::action_t'(s_axis_tuser[2:0]);
    assign cmd.which_stack = s_axis_tuser[3];
    assign cmd.value       = s_axis_tdata;

    dss_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (s_axis_tvalid),
        .cmd_ready (s_axis_tready),
        .cmd       (cmd),
        .capacity  (capacity_reg),
        .cfg_clear (cfg_wr_en),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // load a new result when the output register is empty or being drained
    assign res_ready = !m_valid_reg || m_axis_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {5'b0, out_reg.is_full, out_reg.size_b, out_reg.size_a,
                            out_reg.found_index, out_reg.data};

endmodule
